@@ rtl/age_color_gradient_defines.svh @@
// Assertion helpers for the top-level file, which checks its own logic.
`ifndef AGE_COLOR_GRADIENT_DEFINES_SVH
`define AGE_COLOR_GRADIENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/acg_pkg.sv @@
package acg_pkg;

  localparam int AGE_BITS_DEF = 16;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = COLOR_W / CHAN_W;
  localparam int MAX_AGE_W    = 16;
  localparam int NUM_STOPS    = 6;
  localparam int NUM_SEGS     = 5;
  localparam int SEG_W        = 3;
  // max_age / 5 stays below 2^14, and a step never exceeds span + 2.
  localparam int SPAN_W       = 14;
  localparam int STEP_W       = 14;
  // The scaled difference never exceeds four times a channel range.
  localparam int QUO_W        = 10;
  localparam int REM_W        = CHAN_W + STEP_W;
  localparam int DIV_W        = SPAN_W + QUO_W;
  localparam int SUM_W        = CHAN_W + 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int QUEUE_DEPTH  = 4;

  // x / 5 == (x * 52429) >> 18 for every 16-bit x.
  localparam logic [MAX_AGE_W-1:0] RECIP5       = 16'd52429;
  localparam int                   RECIP5_SHIFT = 18;

  localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = 16'd100;
  localparam logic [SPAN_W-1:0]    SPAN_RESET    = SPAN_W'(100 / NUM_SEGS);
  localparam logic [CHAN_W-1:0]    CHAN_MAX      = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STOP0   = 3'd0,
    REG_STOP1   = 3'd1,
    REG_STOP2   = 3'd2,
    REG_STOP3   = 3'd3,
    REG_STOP4   = 3'd4,
    REG_STOP5   = 3'd5,
    REG_DEAD    = 3'd6,
    REG_MAX_AGE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_STOPS-1:0][COLOR_W-1:0] stop;
    logic [COLOR_W-1:0]                dead;
    logic [MAX_AGE_W-1:0]              max_age;
    logic [SPAN_W-1:0]                 span;
    // Segment start k * span for k = 1..4; index 0 is unused.
    logic [NUM_SEGS-1:0][MAX_AGE_W-1:0] th;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] from_color;
    logic [COLOR_W-1:0] to_color;
    logic [STEP_W-1:0]  step;
  } front_item_t;

  typedef struct packed {
    logic              neg;
    logic [CHAN_W-1:0] from;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_CHAN-1:0] lane;
  } back_item_t;

endpackage

@@ rtl/acg_regs.sv @@
module acg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [acg_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [acg_pkg::COLOR_W-1:0]   cfg_data_i,
  output acg_pkg::cfg_t                 cfg_o
);

  logic [2*acg_pkg::MAX_AGE_W-1:0] span_prod;
  logic [acg_pkg::SPAN_W-1:0]      span_raw;
  logic [acg_pkg::SPAN_W-1:0]      span_d;
  logic [acg_pkg::MAX_AGE_W-1:0]   span_ext;
  logic [acg_pkg::NUM_SEGS-1:0][acg_pkg::MAX_AGE_W-1:0] th_d;
  acg_pkg::cfg_t                   cfg_q;

  // The span and the segment starts are worked out when max_age is written.
  always_comb begin
    span_prod = (2*acg_pkg::MAX_AGE_W)'(cfg_data_i[acg_pkg::MAX_AGE_W-1:0]) *
                (2*acg_pkg::MAX_AGE_W)'(acg_pkg::RECIP5);
    span_raw  = span_prod[acg_pkg::RECIP5_SHIFT +: acg_pkg::SPAN_W];
    span_d    = (span_raw == '0) ? acg_pkg::SPAN_W'(1) : span_raw;
    span_ext  = acg_pkg::MAX_AGE_W'(span_d);
    th_d[0]   = '0;
    th_d[1]   = span_ext;
    th_d[2]   = span_ext << 1;
    th_d[3]   = span_ext + (span_ext << 1);
    th_d[4]   = span_ext << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop    <= '0;
      cfg_q.dead    <= '0;
      cfg_q.max_age <= acg_pkg::MAX_AGE_RESET;
      cfg_q.span    <= acg_pkg::SPAN_RESET;
      cfg_q.th[0]   <= '0;
      cfg_q.th[1]   <= acg_pkg::MAX_AGE_W'(acg_pkg::SPAN_RESET);
      cfg_q.th[2]   <= acg_pkg::MAX_AGE_W'(acg_pkg::SPAN_RESET) << 1;
      cfg_q.th[3]   <= acg_pkg::MAX_AGE_W'(acg_pkg::SPAN_RESET) * acg_pkg::MAX_AGE_W'(3);
      cfg_q.th[4]   <= acg_pkg::MAX_AGE_W'(acg_pkg::SPAN_RESET) << 2;
    end else if (cfg_we_i) begin
      case (acg_pkg::cfg_reg_e'(cfg_addr_i))
        acg_pkg::REG_STOP0: cfg_q.stop[0] <= cfg_data_i;
        acg_pkg::REG_STOP1: cfg_q.stop[1] <= cfg_data_i;
        acg_pkg::REG_STOP2: cfg_q.stop[2] <= cfg_data_i;
        acg_pkg::REG_STOP3: cfg_q.stop[3] <= cfg_data_i;
        acg_pkg::REG_STOP4: cfg_q.stop[4] <= cfg_data_i;
        acg_pkg::REG_STOP5: cfg_q.stop[5] <= cfg_data_i;
        acg_pkg::REG_DEAD:  cfg_q.dead    <= cfg_data_i;
        acg_pkg::REG_MAX_AGE: begin
          cfg_q.max_age <= cfg_data_i[acg_pkg::MAX_AGE_W-1:0];
          cfg_q.span    <= span_d;
          cfg_q.th      <= th_d;
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/acg_front.sv @@
module acg_front #(
  parameter int AGE_BITS = acg_pkg::AGE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  acg_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [AGE_BITS-1:0]   age_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output acg_pkg::front_item_t  item_o
);

  localparam int CMP_W = (AGE_BITS > acg_pkg::MAX_AGE_W) ? AGE_BITS : acg_pkg::MAX_AGE_W;

  logic [CMP_W-1:0]              age_ext;
  logic [CMP_W-1:0]              max_ext;
  logic [CMP_W-1:0]              age_m1;
  logic [acg_pkg::MAX_AGE_W-1:0] pos;
  logic [acg_pkg::MAX_AGE_W-1:0] base;
  logic [acg_pkg::MAX_AGE_W-1:0] step_full;
  logic [acg_pkg::SEG_W-1:0]     seg;
  logic [acg_pkg::COLOR_W-1:0]   seg_from;
  logic [acg_pkg::COLOR_W-1:0]   seg_to;
  logic                          accept;
  acg_pkg::front_item_t          item_d;
  acg_pkg::front_item_t          item_q;
  logic                          valid_d;
  logic                          valid_q;

  always_comb begin
    age_ext = CMP_W'(age_i);
    max_ext = CMP_W'(cfg_i.max_age);
    age_m1  = age_ext - CMP_W'(1);
    pos     = age_m1[acg_pkg::MAX_AGE_W-1:0];

    // The segment is the number of segment starts at or below the position,
    // which also clamps it to the last segment.
    seg = '0;
    for (int k = 1; k < acg_pkg::NUM_SEGS; k++) begin
      seg = seg + acg_pkg::SEG_W'(pos >= cfg_i.th[k]);
    end

    case (seg)
      3'd0: begin
        base = '0;
        seg_from = cfg_i.stop[0];
        seg_to   = cfg_i.stop[1];
      end
      3'd1: begin
        base = cfg_i.th[1];
        seg_from = cfg_i.stop[1];
        seg_to   = cfg_i.stop[2];
      end
      3'd2: begin
        base = cfg_i.th[2];
        seg_from = cfg_i.stop[2];
        seg_to   = cfg_i.stop[3];
      end
      3'd3: begin
        base = cfg_i.th[3];
        seg_from = cfg_i.stop[3];
        seg_to   = cfg_i.stop[4];
      end
      default: begin
        base = cfg_i.th[4];
        seg_from = cfg_i.stop[4];
        seg_to   = cfg_i.stop[5];
      end
    endcase
    step_full = pos - base;

    // Fixed colors leave with a zero step, so the back end passes them through.
    if (age_i == '0) begin
      item_d.from_color = cfg_i.dead;
      item_d.to_color   = cfg_i.dead;
      item_d.step       = '0;
    end else if (age_ext >= max_ext) begin
      item_d.from_color = cfg_i.stop[5];
      item_d.to_color   = cfg_i.stop[5];
      item_d.step       = '0;
    end else begin
      item_d.from_color = seg_from;
      item_d.to_color   = seg_to;
      item_d.step       = step_full[acg_pkg::STEP_W-1:0];
    end
  end

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

@@ rtl/acg_queue.sv @@
module acg_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  acg_pkg::front_item_t item_i,
  input  logic                 pop_i,
  output acg_pkg::front_item_t item_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int PTR_W = $clog2(acg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(acg_pkg::QUEUE_DEPTH + 1);

  acg_pkg::front_item_t mem_q [acg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     cnt_d;

  assign full_o  = (cnt_q == CNT_W'(acg_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/acg_back.sv @@
module acg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [acg_pkg::SPAN_W-1:0]  span_i,
  input  logic                        q_empty_i,
  input  acg_pkg::front_item_t        q_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [acg_pkg::COLOR_W-1:0] color_o
);

  localparam int NSTG = acg_pkg::QUO_W;

  // One restoring division step: try to take span << b off the remainder.
  function automatic acg_pkg::lane_t div_bit(acg_pkg::lane_t l,
                                             logic [acg_pkg::SPAN_W-1:0] span,
                                             int unsigned b);
    logic [acg_pkg::DIV_W-1:0] dvs;
    logic [acg_pkg::DIV_W-1:0] r;
    acg_pkg::lane_t            o;
    o   = l;
    dvs = acg_pkg::DIV_W'(span) << b;
    r   = acg_pkg::DIV_W'(l.rem);
    if (r >= dvs) begin
      o.rem = acg_pkg::REM_W'(r - dvs);
      o.quo = l.quo | (acg_pkg::QUO_W'(1) << b);
    end
    return o;
  endfunction

  logic                         adv;
  acg_pkg::back_item_t          mul_d;
  acg_pkg::back_item_t          stage_q [NSTG+1];
  acg_pkg::back_item_t          stage_d [NSTG+1];
  logic [NSTG:0]                valid_q;
  logic [acg_pkg::COLOR_W-1:0]  color_d;
  logic [acg_pkg::COLOR_W-1:0]  color_q;
  logic                         out_valid_q;

  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && !q_empty_i;

  // Multiply stage: the magnitude of the channel difference times the step.
  always_comb begin
    logic [acg_pkg::CHAN_W-1:0] fc;
    logic [acg_pkg::CHAN_W-1:0] tc;
    logic [acg_pkg::CHAN_W-1:0] mag;
    for (int c = 0; c < acg_pkg::NUM_CHAN; c++) begin
      fc  = q_item_i.from_color[c*acg_pkg::CHAN_W +: acg_pkg::CHAN_W];
      tc  = q_item_i.to_color[c*acg_pkg::CHAN_W +: acg_pkg::CHAN_W];
      mag = (tc < fc) ? (fc - tc) : (tc - fc);
      mul_d.lane[c].neg  = (tc < fc);
      mul_d.lane[c].from = fc;
      mul_d.lane[c].rem  = acg_pkg::REM_W'(mag) * acg_pkg::REM_W'(q_item_i.step);
      mul_d.lane[c].quo  = '0;
    end
  end

  assign stage_d[0] = mul_d;

  // Divider stages, most significant quotient bit first.
  for (genvar i = 1; i <= NSTG; i++) begin : g_div
    for (genvar c = 0; c < acg_pkg::NUM_CHAN; c++) begin : g_chan
      assign stage_d[i].lane[c] = div_bit(stage_q[i-1].lane[c], span_i, NSTG - i);
    end
  end

  // Apply the signed quotient to the start color and clamp to a channel.
  always_comb begin
    logic [acg_pkg::SUM_W-1:0] v;
    acg_pkg::lane_t            l;
    color_d = '0;
    for (int c = 0; c < acg_pkg::NUM_CHAN; c++) begin
      l = stage_q[NSTG].lane[c];
      if (l.neg) begin
        v = acg_pkg::SUM_W'(l.from) - acg_pkg::SUM_W'(l.quo);
      end else begin
        v = acg_pkg::SUM_W'(l.from) + acg_pkg::SUM_W'(l.quo);
      end
      if (v[acg_pkg::SUM_W-1]) begin
        color_d[c*acg_pkg::CHAN_W +: acg_pkg::CHAN_W] = '0;
      end else if (v[acg_pkg::SUM_W-2:acg_pkg::CHAN_W] != '0) begin
        color_d[c*acg_pkg::CHAN_W +: acg_pkg::CHAN_W] = acg_pkg::CHAN_MAX;
      end else begin
        color_d[c*acg_pkg::CHAN_W +: acg_pkg::CHAN_W] = v[acg_pkg::CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[NSTG-1:0], pop_o};
      out_valid_q <= valid_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= NSTG; i++) begin
        stage_q[i] <= stage_d[i];
      end
      color_q <= color_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign color_o     = color_q;

endmodule

@@ rtl/age_color_gradient.sv @@
// Age to color gradient.
// Input channel: in_valid_i / in_stall_o carry one age per item. Output channel:
// out_valid_o / out_stall_i carry one 24-bit RGB color per item, red in bits
// 23..16. Each side completes a transfer when valid is high and stall is low.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_addr_i (stop
// colors 0..5, then dead color, then max age). Write only while no item
// is in flight.
// Each item passes through one classify stage, one queue slot, one multiply
// stage, ten restoring divider stages of one quotient bit each, and the
// clamp into the output register. Throughput is one item per clock while
// the receiver does not stall the output.
// A four-entry queue sits between the classify stage and the divider pipe.
// While the receiver stalls, the whole divider pipe holds and the queue
// fills; the input stalls once the queue and the classify register are full.
// Reset clears every color to black and sets max age to 100, and empties
// the queue and pipeline.
`include "age_color_gradient_defines.svh"

module age_color_gradient #(
  parameter int AGE_BITS = acg_pkg::AGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acg_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [acg_pkg::COLOR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [AGE_BITS-1:0]            age_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [acg_pkg::COLOR_W-1:0]    color_o
);

  acg_pkg::cfg_t        cfg;
  acg_pkg::front_item_t front_item;
  acg_pkg::front_item_t queue_item;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;

  acg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  acg_front #(
    .AGE_BITS (AGE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .age_i      (age_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  acg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .item_o  (queue_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  acg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .span_i      (cfg.span),
    .q_empty_i   (q_empty),
    .q_item_i    (queue_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .color_o     (color_o)
  );

  `ACG_ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, q_push, !q_full, "push into a full queue")
  `ACG_ASSERT_IMPLY(a_no_pop_empty, clk_i, rst_ni, q_pop, !q_empty, "pop from an empty queue")
  `ACG_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_stall_o && !q_pop, in_stall_o, "input stall released without a pop")

endmodule

@@ bench/age_color_gradient_tb.sv @@
module age_color_gradient_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acg_pkg::*;

  localparam int AW          = AGE_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_TAIL  = 16;

  typedef logic [COLOR_W-1:0] stop_set_t [NUM_STOPS];

  class gradient_board;
    logic [COLOR_W-1:0]   stops [NUM_STOPS];
    logic [COLOR_W-1:0]   dead;
    logic [MAX_AGE_W-1:0] max_age;
    logic [COLOR_W-1:0]   pending_colors [$];
    int                   n_checked;
    int                   n_errors;

    function new();
      foreach (stops[k]) stops[k] = '0;
      dead      = '0;
      max_age   = MAX_AGE_RESET;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [COLOR_W-1:0] d);
      case (idx)
        REG_DEAD: begin
          dead = d;
        end
        REG_MAX_AGE: begin
          max_age = d[MAX_AGE_W-1:0];
        end
        default: begin
          stops[idx] = d;
        end
      endcase
    endfunction

    function logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] f, logic [CHAN_W-1:0] t,
                                           longint step, longint span);
      longint v;
      // Signed division truncates toward zero, then the channel saturates.
      v = longint'(f) + ((longint'(t) - longint'(f)) * step) / span;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[CHAN_W-1:0];
    endfunction

    function logic [COLOR_W-1:0] gradient_color(logic [AW-1:0] a);
      longint             span;
      longint             seg;
      longint             step;
      logic [COLOR_W-1:0] from_c;
      logic [COLOR_W-1:0] to_c;
      logic [COLOR_W-1:0] c;
      if (a == 0) return dead;
      if (longint'(a) >= longint'(max_age)) return stops[NUM_STOPS-1];
      span = longint'(max_age) / NUM_SEGS;
      if (span == 0) span = 1;
      seg = (longint'(a) - 1) / span;
      if (seg > NUM_SEGS - 1) seg = NUM_SEGS - 1;
      step   = longint'(a) - 1 - seg * span;
      from_c = stops[seg];
      to_c   = stops[seg+1];
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        c[ch*CHAN_W +: CHAN_W] = blend_chan(from_c[ch*CHAN_W +: CHAN_W],
                                            to_c[ch*CHAN_W +: CHAN_W], step, span);
      end
      return c;
    endfunction

    function void take_age(logic [AW-1:0] a);
      pending_colors.push_back(gradient_color(a));
    endfunction

    task report(string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task match_color(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (pending_colors.size() == 0) begin
        report($sformatf("color %06h arrived with nothing outstanding", got));
      end else begin
        want = pending_colors.pop_front();
        n_checked++;
        if (got !== want) report($sformatf("color %06h, predicted %06h", got, want));
      end
    endtask

    function int pending();
      return pending_colors.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [COLOR_W-1:0]    cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [AW-1:0]         age_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [COLOR_W-1:0]    color_o;

  gradient_board sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            cur_max;
  int            n_sent;
  int            n_settings;
  int            quiet_cycles;

  age_color_gradient #(.AGE_BITS(AW)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .age_i      (age_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .color_o    (color_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: check each accepted color, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) sb.match_color(color_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("No item moved for %0d cycles.", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_age(logic [AW-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    age_i      <= a;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_age(a);
    n_sent++;
  endtask

  task run_ages(input int list[$]);
    foreach (list[k]) send_age(AW'(list[k]));
  endtask

  task wait_drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task write_reg(cfg_reg_e idx, logic [COLOR_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  // Registers only change with the pipeline empty.
  task load_config(stop_set_t s, logic [COLOR_W-1:0] dead, logic [COLOR_W-1:0] max_word);
    wait_drain();
    for (int k = 0; k < NUM_STOPS; k++) write_reg(cfg_reg_e'(REG_STOP0 + k), s[k]);
    write_reg(REG_DEAD, dead);
    write_reg(REG_MAX_AGE, max_word);
    cfg_we_i <= 1'b0;
    cur_max = int'(max_word[MAX_AGE_W-1:0]);
    n_settings++;
  endtask

  initial begin
    stop_set_t     rainbow;
    stop_set_t     overshoot;
    stop_set_t     stripes;
    stop_set_t     rnd_stops;
    logic [COLOR_W-1:0] rnd_dead;
    logic [COLOR_W-1:0] pick;
    int            m;
    logic [AW-1:0] next_age;
    int            send_pct_tab [3];
    int            recv_pct_tab [3];

    sb            = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= REG_STOP0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    age_i         <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_max       = int'(MAX_AGE_RESET);
    n_sent        = 0;
    n_settings    = 0;
    send_pct_tab  = '{10, 71, 0};
    recv_pct_tab  = '{71, 10, 0};
    rainbow   = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000, 24'h80C040};
    overshoot = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'hF00080, 24'h00FF00};
    stripes   = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: every color black, max age 100.
    run_ages('{0, 100});
    load_config(rainbow, 24'h123456, 24'd100);
    run_ages('{0, 1, 20, 21, 41, 81, 99, 100, 65535});
    // Max age not a multiple of five: the last segment runs past its stop and saturates.
    load_config(overshoot, 24'h123456, 24'd103);
    run_ages('{81, 101, 102, 103});
    // Span of one with bits above the max age field set in the write data.
    load_config(overshoot, 24'h654321, 24'hAB0009);
    run_ages('{1, 2, 5, 6, 8, 9});
    // Max age below five forces the span to one; zero sends every live age to the last stop.
    load_config(rainbow, 24'h00FF00, 24'd3);
    run_ages('{1, 2, 3});
    load_config(rainbow, 24'h00FF00, 24'd0);
    run_ages('{1, 0});
    load_config(stripes, 24'hFFFFFF, 24'd65535);
    run_ages('{13107, 13108, 65534});

    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k <= NUM_STOPS; k++) begin
          case ($urandom_range(7))
            0: pick = '0;
            1: pick = '1;
            default: pick = COLOR_W'($urandom());
          endcase
          if (k < NUM_STOPS) rnd_stops[k] = pick;
          else rnd_dead = pick;
        end
        case ($urandom_range(4))
          0: m = $urandom_range(12, 5);
          1: m = $urandom_range(200, 13);
          2: m = $urandom_range(65535, 201);
          3: m = 65535;
          default: m = 5;
        endcase
        load_config(rnd_stops, rnd_dead, {8'($urandom()), 16'(m)});
        send_idle_pct = send_pct_tab[p];
        recv_idle_pct = recv_pct_tab[p];
        repeat (170) begin
          case ($urandom_range(9))
            0: next_age = '0;
            1: next_age = AW'($urandom_range(65535));
            2: next_age = AW'(cur_max);
            3: next_age = AW'(cur_max - 1);
            default: next_age = AW'($urandom_range((cur_max + 3 > 65535) ? 65535 : cur_max + 3, 1));
          endcase
          send_age(next_age);
        end
      end
    end

    wait_drain();
    $display("Sent %0d ages under %0d register settings; %0d colors compared.",
             n_sent, n_settings, sb.n_checked);
    $display("Traffic ran with sender gaps, receiver stalls, both swapped, and back to back.");
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", sb.n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
